// ===== hw/rtl/packed_vertex_half_to_float_assert.svh =====
// assertion macros for the half to float vertex converter
`ifndef PACKED_VERTEX_HALF_TO_FLOAT_ASSERT_SVH
`define PACKED_VERTEX_HALF_TO_FLOAT_ASSERT_SVH
`ifndef SYNTHESIS
`define PVH_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define PVH_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define PVH_ASSERT_IMP(label, clk, rst, a, c)
`define PVH_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

// ===== hw/rtl/pvh_pkg.sv =====
// shared types and constants for the half to float vertex converter
`default_nettype none
package pvh_pkg;
  localparam int NumVals = 5;
  localparam logic [7:0] SingleExpMax = 8'd255;
  localparam logic [7:0] ExpRebias = 8'd112;

  // stage 1 decode of one half value
  typedef struct packed {
    logic       sign;
    logic [4:0] exp;
    logic [9:0] man;
    logic       is_zero;
    logic       is_sub;
    logic       is_max;
    logic [3:0] lz;
  } pvh_dec_t;

  // stage 2 partial result
  typedef struct packed {
    logic       sign;
    logic [7:0] exp;
    logic [9:0] man;
    logic       is_sub;
    logic [3:0] shift;
  } pvh_mid_t;
endpackage
`default_nettype wire

// ===== hw/rtl/packed_vertex_half_to_float.sv =====
// top level: packed vertex binary16 to binary32 converter
// an accepted input passes through the dec, mid and f stage registers before output valid
// throughput: one transaction per cycle when out_stall is low, set by the three-stage lane pipeline
// stall from the output backs up through all three stages with no loss
// synchronous active-high reset clears the stage valid bits only
`default_nettype none
module packed_vertex_half_to_float import pvh_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] x_half,
  input  wire logic [15:0] y_half,
  input  wire logic [15:0] z_half,
  input  wire logic [15:0] u_half,
  input  wire logic [15:0] v_half,
  input  wire logic [31:0] color_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [31:0] x_single,
  output logic      [31:0] y_single,
  output logic      [31:0] z_single,
  output logic      [31:0] u_single,
  output logic      [31:0] v_single,
  output logic      [31:0] color_out
);
  logic [2:0] en;
  logic [15:0] h [NumVals];
  logic [31:0] f [NumVals];
  logic [31:0] c0, c1;

  assign h[0] = x_half;
  assign h[1] = y_half;
  assign h[2] = z_half;
  assign h[3] = u_half;
  assign h[4] = v_half;
  assign x_single = f[0];
  assign y_single = f[1];
  assign z_single = f[2];
  assign u_single = f[3];
  assign v_single = f[4];

  pvh_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .en(en)
  );

  for (genvar g = 0; g < NumVals; g++) begin : g_lane
    pvh_lane u_lane (.clk(clk), .en(en), .h(h[g]), .f(f[g]));
  end

  always_ff @(posedge clk) begin
    if (en[0]) c0 <= color_in;
    if (en[1]) c1 <= c0;
    if (en[2]) color_out <= c1;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/pvh_lane.sv =====
// three-stage binary16 to binary32 conversion lane
`default_nettype none
module pvh_lane import pvh_pkg::*; (
  input  wire logic        clk,
  input  wire logic [2:0]  en,
  input  wire logic [15:0] h,
  output logic      [31:0] f
);
  pvh_dec_t dec, dec_next;
  pvh_mid_t mid, mid_next;
  logic [31:0] f_next;
  logic [9:0] sh;

  always_comb begin
    dec_next.sign = h[15];
    dec_next.exp = h[14:10];
    dec_next.man = h[9:0];
    dec_next.is_zero = (h[14:0] == 15'd0);
    dec_next.is_sub = (h[14:10] == 5'd0) && (h[9:0] != 10'd0);
    dec_next.is_max = (h[14:10] == 5'h1f);
    dec_next.lz = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (h[i]) dec_next.lz = 4'(10 - i);
    end
  end

  always_comb begin
    mid_next.sign = dec.sign;
    mid_next.man = dec.man;
    mid_next.is_sub = dec.is_sub;
    mid_next.shift = dec.lz;
    if (dec.is_zero) mid_next.exp = 8'd0;
    else if (dec.is_sub) mid_next.exp = ExpRebias + 8'd1 - {4'd0, dec.lz};
    else if (dec.is_max) mid_next.exp = SingleExpMax;
    else mid_next.exp = {3'd0, dec.exp} + ExpRebias;
  end

  always_comb begin
    sh = mid.is_sub ? (mid.man << mid.shift) : mid.man;
    f_next = {mid.sign, mid.exp, sh, 13'd0};
  end

  always_ff @(posedge clk) begin
    if (en[0]) dec <= dec_next;
    if (en[1]) mid <= mid_next;
    if (en[2]) f <= f_next;
  end
endmodule
`default_nettype wire

// ===== hw/rtl/pvh_ctrl.sv =====
// valid and stall control for the three-stage pipeline
`default_nettype none
module pvh_ctrl import pvh_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [2:0] en
);
`include "packed_vertex_half_to_float_assert.svh"
  logic [2:0] vld;
  logic [2:0] vld_next;

  always_comb begin
    en[2] = !vld[2] || !out_stall;
    en[1] = !vld[1] || en[2];
    en[0] = !vld[0] || en[1];
    in_stall = !en[0];
    out_valid = vld[2];
    vld_next[2] = en[2] ? vld[1] : vld[2];
    vld_next[1] = en[1] ? vld[0] : vld[1];
    vld_next[0] = en[0] ? in_valid : vld[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 3'd0;
    end else begin
      vld <= vld_next;
    end
  end

  `PVH_ASSERT_NXT(a_hold, clk, rst, out_valid && out_stall, out_valid)
  `PVH_ASSERT_NXT(a_move, clk, rst, vld[1] && !out_stall, out_valid)
  `PVH_ASSERT_IMP(a_stall, clk, rst, in_stall, vld == 3'b111 && out_stall)
endmodule
`default_nettype wire
